@@ design/spq_pkg.sv @@
package spq_pkg;

   localparam int PRI_BITS = 8;
   localparam int PORT_TAG_BITS = 32;
   localparam int OCC_BITS = 5;

   typedef enum logic [1:0] {
      ST_ADDED  = 2'd0,
      ST_SERVED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

@@ design/spq_cell.sv @@
module spq_cell #(
   parameter int TAG_BITS = 32
) (
   input  logic                          clock,
   input  spq_pkg::cell_ctrl_type        ctrl,
   input  logic [spq_pkg::PRI_BITS-1:0]  new_priority,
   input  logic [TAG_BITS-1:0]           new_tag,
   input  logic [spq_pkg::PRI_BITS-1:0]  left_priority,
   input  logic [TAG_BITS-1:0]           left_tag,
   input  logic                          left_before,
   input  logic [spq_pkg::PRI_BITS-1:0]  right_priority,
   input  logic [TAG_BITS-1:0]           right_tag,
   input  logic                          occupied,
   output logic [spq_pkg::PRI_BITS-1:0]  cell_priority,
   output logic [TAG_BITS-1:0]           cell_tag,
   output logic                          ahead
);

   logic [spq_pkg::PRI_BITS-1:0] priority_ff, priority_in;
   logic [TAG_BITS-1:0]          tag_ff, tag_in;

   // An entry stays ahead of a new one when it is held and its priority is not greater.
   assign ahead = occupied && (priority_ff <= new_priority);

   always_comb begin
      priority_in = priority_ff;
      tag_in      = tag_ff;
      if (ctrl.insert && !ahead) begin
         if (left_before) begin
            priority_in = new_priority;
            tag_in      = new_tag;
         end else begin
            priority_in = left_priority;
            tag_in      = left_tag;
         end
      end else if (ctrl.remove) begin
         priority_in = right_priority;
         tag_in      = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      priority_ff <= priority_in;
      tag_ff      <= tag_in;
   end

   assign cell_priority = priority_ff;
   assign cell_tag      = tag_ff;

endmodule

@@ design/stable_priority_queue_top.sv @@
// Stable priority queue of CAPACITY entries held in a row of compare-and-shift cells, kept
// sorted by priority with equal priorities in arrival order. The block takes one add or serve
// item in every cycle (busy stays low) and gives exactly one result per item on the cycle
// after it is accepted, marked by rsp_strobe for one cycle; the result is not held, so the
// receiver must take it then. An add goes into all cells at once, each comparing itself with
// the new entry, and a serve shifts every cell one place toward the front.
module stable_priority_queue_top #(
   parameter int CAPACITY = 16,
   parameter int TAG_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [spq_pkg::PRI_BITS-1:0]       req_entry_priority,
   input  logic [spq_pkg::PORT_TAG_BITS-1:0]  req_entry_tag,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [spq_pkg::PRI_BITS-1:0]       rsp_served_priority,
   output logic [spq_pkg::PORT_TAG_BITS-1:0]  rsp_served_tag,
   output logic [spq_pkg::OCC_BITS-1:0]       rsp_occupancy
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         rsp_strobe_ff;
   spq_pkg::status_type          rsp_status_ff, status_in;
   logic [spq_pkg::PRI_BITS-1:0] rsp_priority_ff, priority_in;
   logic [spq_pkg::PORT_TAG_BITS-1:0] rsp_tag_ff, tag_in;
   logic [spq_pkg::OCC_BITS-1:0] rsp_occupancy_ff;

   logic                         accept, full, empty;
   spq_pkg::cell_ctrl_type       ctrl;
   logic [TAG_BITS-1:0]          new_tag;
   logic [spq_pkg::PORT_TAG_BITS-1:0] front_tag;

   logic [spq_pkg::PRI_BITS-1:0] cell_priority [CAPACITY];
   logic [TAG_BITS-1:0]          cell_tag [CAPACITY];
   logic                         cell_before [CAPACITY];
   logic                         cell_occupied [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_BITS'(CAPACITY));
   assign empty  = (count_ff == '0);

   assign ctrl.insert = accept && !req_action && !full;
   assign ctrl.remove = accept && req_action && !empty;

   for (genvar b = 0; b < TAG_BITS; b++) begin : g_new_tag
      if (b < spq_pkg::PORT_TAG_BITS) begin : g_bit
         assign new_tag[b] = req_entry_tag[b];
      end else begin : g_zero
         assign new_tag[b] = 1'b0;
      end
   end

   for (genvar b = 0; b < spq_pkg::PORT_TAG_BITS; b++) begin : g_front_tag
      if (b < TAG_BITS) begin : g_bit
         assign front_tag[b] = cell_tag[0][b];
      end else begin : g_zero
         assign front_tag[b] = 1'b0;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [spq_pkg::PRI_BITS-1:0] left_priority, right_priority;
      logic [TAG_BITS-1:0]          left_tag, right_tag;
      logic                         left_before;

      assign cell_occupied[i] = (CNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_priority = req_entry_priority;
         assign left_tag      = new_tag;
         assign left_before   = 1'b1;
      end else begin : g_body
         assign left_priority = cell_priority[i-1];
         assign left_tag      = cell_tag[i-1];
         assign left_before   = cell_before[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_priority = '0;
         assign right_tag      = '0;
      end else begin : g_next
         assign right_priority = cell_priority[i+1];
         assign right_tag      = cell_tag[i+1];
      end

      spq_cell #(
         .TAG_BITS(TAG_BITS)
      ) u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .new_priority   (req_entry_priority),
         .new_tag        (new_tag),
         .left_priority  (left_priority),
         .left_tag       (left_tag),
         .left_before    (left_before),
         .right_priority (right_priority),
         .right_tag      (right_tag),
         .occupied       (cell_occupied[i]),
         .cell_priority  (cell_priority[i]),
         .cell_tag       (cell_tag[i]),
         .ahead          (cell_before[i])
      );
   end

   always_comb begin
      count_in    = count_ff;
      status_in   = spq_pkg::ST_ADDED;
      priority_in = '0;
      tag_in      = '0;
      if (req_action) begin
         if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else begin
            status_in   = spq_pkg::ST_SERVED;
            priority_in = cell_priority[0];
            tag_in      = front_tag;
         end
      end else if (full) begin
         status_in = spq_pkg::ST_FULL;
      end
      if (ctrl.insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      if (accept) begin
         rsp_status_ff    <= status_in;
         rsp_priority_ff  <= priority_in;
         rsp_tag_ff       <= tag_in;
         rsp_occupancy_ff <= spq_pkg::OCC_BITS'(count_in);
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_served_priority = rsp_priority_ff;
   assign rsp_served_tag      = rsp_tag_ff;
   assign rsp_occupancy       = rsp_occupancy_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("An accepted item gave no result.");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("A result appeared without an item.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("The entry count exceeds the capacity.");

   a_serve_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove |=> count_ff == $past(count_ff) - CNT_BITS'(1))
      else $error("A serve did not remove exactly one entry.");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_BITS'(2) |-> cell_priority[0] <= cell_priority[1])
      else $error("The front entries are out of order.");

endmodule

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 16;
   localparam int QUEUE_TAG_BITS = 32;
   localparam int ITEMS_PER_PHASE = 382;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_SERVE = 1'b1;

   typedef struct {
      spq_pkg::status_type                      status;
      logic [spq_pkg::PRI_BITS-1:0]       pri;
      logic [spq_pkg::PORT_TAG_BITS-1:0]  tag;
      logic [spq_pkg::OCC_BITS-1:0]       occ;
   } outcome_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic                               req_action = ACT_ADD;
   logic [spq_pkg::PRI_BITS-1:0]       req_entry_priority = '0;
   logic [spq_pkg::PORT_TAG_BITS-1:0]  req_entry_tag = '0;
   logic                               rsp_strobe;
   logic [1:0]                         rsp_status;
   logic [spq_pkg::PRI_BITS-1:0]       rsp_served_priority;
   logic [spq_pkg::PORT_TAG_BITS-1:0]  rsp_served_tag;
   logic [spq_pkg::OCC_BITS-1:0]       rsp_occupancy;

   logic [spq_pkg::PRI_BITS-1:0]       held_pri [CAPACITY];
   logic [spq_pkg::PORT_TAG_BITS-1:0]  held_tag [CAPACITY];
   int                                 held_count = 0;
   outcome_type                        outcomes_due [$];
   int                                 idle_pct = 0;
   int                                 quiet_cycles = 0;
   bit                                 failed = 1'b0;

   stable_priority_queue_top #(
      .CAPACITY(CAPACITY),
      .TAG_BITS(QUEUE_TAG_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_entry_priority(req_entry_priority),
      .req_entry_tag(req_entry_tag),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_served_priority(rsp_served_priority),
      .rsp_served_tag(rsp_served_tag),
      .rsp_occupancy(rsp_occupancy)
   );

   always #4 clock = ~clock;

   function automatic outcome_type queue_outcome(
         input logic action,
         input logic [spq_pkg::PRI_BITS-1:0] pri,
         input logic [spq_pkg::PORT_TAG_BITS-1:0] tag);
      outcome_type o;
      int slot;
      o.status = spq_pkg::ST_ADDED;
      o.pri = '0;
      o.tag = '0;
      if (action == ACT_ADD) begin
         if (held_count >= CAPACITY) begin
            o.status = spq_pkg::ST_FULL;
         end else begin
            slot = 0;
            while (slot < held_count && held_pri[slot] <= pri) slot++;
            for (int i = held_count; i > slot; i--) begin
               held_pri[i] = held_pri[i-1];
               held_tag[i] = held_tag[i-1];
            end
            held_pri[slot] = pri;
            held_tag[slot] = tag;
            held_count++;
         end
      end else if (held_count == 0) begin
         o.status = spq_pkg::ST_EMPTY;
      end else begin
         o.status = spq_pkg::ST_SERVED;
         o.pri = held_pri[0];
         o.tag = held_tag[0];
         for (int i = 1; i < held_count; i++) begin
            held_pri[i-1] = held_pri[i];
            held_tag[i-1] = held_tag[i];
         end
         held_count--;
      end
      o.occ = spq_pkg::OCC_BITS'(held_count);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type due;
      if (!reset && rsp_strobe) begin
         if (outcomes_due.size() == 0) begin
            $error("Result arrived with no item outstanding.");
            failed = 1'b1;
         end else begin
            due = outcomes_due.pop_front();
            if (rsp_status !== due.status) begin
               $error("status: expected %0d, actual %0d", due.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_served_priority !== due.pri) begin
               $error("served_priority: expected %0d, actual %0d",
                      due.pri, rsp_served_priority);
               failed = 1'b1;
            end
            if (rsp_served_tag !== due.tag) begin
               $error("served_tag: expected %h, actual %h", due.tag, rsp_served_tag);
               failed = 1'b1;
            end
            if (rsp_occupancy !== due.occ) begin
               $error("occupancy: expected %0d, actual %0d", due.occ, rsp_occupancy);
               failed = 1'b1;
            end
         end
      end
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic action, input logic [spq_pkg::PRI_BITS-1:0] pri,
                            input logic [spq_pkg::PORT_TAG_BITS-1:0] tag);
      start <= 1'b1;
      req_action <= action;
      req_entry_priority <= pri;
      req_entry_tag <= tag;
      do @(posedge clock); while (busy !== 1'b0);
      outcomes_due.push_back(queue_outcome(action, pri, tag));
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (outcomes_due.size() != 0);
      @(posedge clock);
   endtask

   task automatic test_serve_empty();
      send_item(ACT_SERVE, '1, '1);
   endtask

   task automatic test_extremes();
      send_item(ACT_ADD, 8'd255, 32'h0000_0000);
      send_item(ACT_ADD, 8'd0, 32'hFFFF_FFFF);
      send_item(ACT_SERVE, 8'h5A, 32'hA5A5_5A5A);
   endtask

   task automatic test_equal_priority();
      send_item(ACT_ADD, 8'd128, 32'h0000_0001);
      send_item(ACT_ADD, 8'd128, 32'h0000_0002);
      send_item(ACT_ADD, 8'd128, 32'h0000_0003);
      send_item(ACT_ADD, 8'd255, 32'h0000_0004);
   endtask

   task automatic test_full();
      while (held_count < CAPACITY) begin
         send_item(ACT_ADD, spq_pkg::PRI_BITS'($urandom_range(126, 130)), $urandom);
      end
      send_item(ACT_ADD, 8'd0, 32'hDEAD_BEEF);
      send_item(ACT_SERVE, '0, '0);
   endtask

   task automatic test_random_mix(input int count);
      int add_pct;
      logic [spq_pkg::PRI_BITS-1:0] pri;
      add_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) begin
            add_pct = 25 + 25 * $urandom_range(2);
         end
         if ($urandom_range(1) == 0) begin
            pri = spq_pkg::PRI_BITS'($urandom_range(7));
         end else begin
            pri = spq_pkg::PRI_BITS'($urandom);
         end
         send_item(($urandom_range(99) < add_pct) ? ACT_ADD : ACT_SERVE, pri, $urandom);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_serve_empty();
      test_extremes();
      test_equal_priority();
      test_full();
      wait_drained();
      idle_pct = 0;
      test_random_mix(ITEMS_PER_PHASE);
      wait_drained();
      idle_pct = 69;
      test_random_mix(ITEMS_PER_PHASE);
      wait_drained();
      idle_pct = 0;
      test_random_mix(ITEMS_PER_PHASE);
      wait_drained();
      idle_pct = 23;
      test_random_mix(ITEMS_PER_PHASE);
      wait_drained();
      repeat (4) @(posedge clock);
      if (failed || outcomes_due.size() != 0) begin
         $display("RESULT: ERROR");
      end else begin
         $display("RESULT: OK");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_top.sv
tb/testbench.sv
